// ----- hw/rtl/plp_pkg.sv -----
package plp_pkg;

    // Default fixed point format and coordinate mask
    localparam int FRAC_BITS_DEF  = 8;
    localparam int COORD_BITS_DEF = 10;

    // Port field widths
    localparam int PIX_W    = 10;
    localparam int POS_W    = 16;
    localparam int OFS_W    = 24;
    localparam int REGION_W = 3;

    // Register widths
    localparam int VR_W   = 21;
    localparam int VC_W   = 21;
    localparam int BR_W   = 10;
    localparam int BC_W   = 10;
    localparam int EDGE_W = 24;
    localparam int NUM_EDGES = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VANISH_ROW      = 3'd0,
        REG_VANISH_COL      = 3'd1,
        REG_BASE_ROW        = 3'd2,
        REG_BASE_COL        = 3'd3,
        REG_LANE_EDGE_ZERO  = 3'd4,
        REG_LANE_EDGE_ONE   = 3'd5,
        REG_LANE_EDGE_TWO   = 3'd6,
        REG_LANE_EDGE_THREE = 3'd7
    } t_reg_idx;

    // Reset values (8 fraction bits, BR/BC integer)
    localparam logic signed [VR_W-1:0]   VR_RST = -21'sd35258;
    localparam logic signed [VC_W-1:0]   VC_RST = 21'sd20090;
    localparam logic [BR_W-1:0]          BR_RST = 10'd180;
    localparam logic [BC_W-1:0]          BC_RST = 10'd27;
    localparam logic signed [EDGE_W-1:0] E0_RST = -24'sd256;
    localparam logic signed [EDGE_W-1:0] E1_RST = 24'sd27648;
    localparam logic signed [EDGE_W-1:0] E2_RST = 24'sd54528;
    localparam logic signed [EDGE_W-1:0] E3_RST = 24'sd80889;

    // Saturation limits
    localparam int OFS_MAX = 8388607;
    localparam int OFS_MIN = -8388608;
    localparam int POS_MAX = 65535;

    // Region codes
    localparam logic [REGION_W-1:0] REGION_LEFT   = 3'd0;
    localparam logic [REGION_W-1:0] REGION_LANE1  = 3'd1;
    localparam logic [REGION_W-1:0] REGION_LANE2  = 3'd2;
    localparam logic [REGION_W-1:0] REGION_LANE3  = 3'd3;
    localparam logic [REGION_W-1:0] REGION_BEYOND = 3'd4;

endpackage

// ----- hw/rtl/plp_pix_if.sv -----
interface plp_pix_if;
    logic                        valid;
    logic                        ready;
    logic [plp_pkg::PIX_W-1:0]   pixel_row;
    logic [plp_pkg::PIX_W-1:0]   pixel_col;

    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// ----- hw/rtl/plp_lane_if.sv -----
interface plp_lane_if;
    logic                               valid;
    logic                               ready;
    logic [plp_pkg::POS_W-1:0]          lane_position;
    logic signed [plp_pkg::OFS_W-1:0]   cross_offset;
    logic [plp_pkg::REGION_W-1:0]       region;
    logic                               fault;

    modport source (output valid, output lane_position, output cross_offset,
                    output region, output fault, input ready);
    modport sink   (input valid, input lane_position, input cross_offset,
                    input region, input fault, output ready);
endinterface

// ----- hw/rtl/pixel_to_lane_position.sv -----
// Pixel to lane position mapper.
// i_pix carries one query (pixel_row, pixel_col) per transaction; o_lane returns
// exactly one result transaction per query, in order: lane_position (8.8 style,
// FRAC_BITS fraction bits), cross_offset (signed, FRAC_BITS fraction bits),
// region (0 left, 1..3 lanes, 4 beyond) and fault.
// Throughput: one query per cycle while the receiver does not stall. The
// pipeline is stages A, B and C, a chain of divider cells, stages D1, D2, E1,
// E2 and E3, a second chain of divider cells, then F1 and F2; its depth is
// set by the two divider chains, one cell per quotient bit.
// The whole pipeline advances together; it moves whenever the output register
// is empty or being taken. When the receiver stalls with a result held, the
// pipeline freezes and i_pix.ready drops in the same cycle.
// Synchronous active-low reset clears all stage valids and loads the
// calibration registers with their defaults. Configuration writes (i_cfg_we,
// i_cfg_idx, i_cfg_data) take effect at once and must only happen while no
// transaction is in flight.
module pixel_to_lane_position #(
    parameter int FRAC_BITS  = plp_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = plp_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [plp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [plp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    plp_pix_if.sink                          i_pix,
    plp_lane_if.source                       o_lane
);

    localparam int PW   = plp_pkg::PIX_W;
    localparam int OW   = plp_pkg::OFS_W;
    localparam int EW   = plp_pkg::EDGE_W;
    localparam int RW   = plp_pkg::REGION_W;
    localparam int POSW = plp_pkg::POS_W;
    // working width for the perspective terms
    localparam int AW0  = (plp_pkg::VR_W > PW + FRAC_BITS + 1) ?
                          plp_pkg::VR_W : PW + FRAC_BITS + 1;
    localparam int W    = AW0 + 1;
    localparam int NW1  = 2 * W;
    localparam int NW2  = OW + FRAC_BITS;
    localparam int DW2  = OW;
    localparam int PSW  = NW2 + 2;

    localparam logic [PW-1:0] COORD_MASK = PW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic signed [NW1:0]   HW_MAX  = (NW1+1)'(plp_pkg::OFS_MAX);
    localparam logic signed [NW1:0]   HW_MIN  = (NW1+1)'(plp_pkg::OFS_MIN);
    localparam logic signed [PSW-1:0] PS_MAX  = PSW'(plp_pkg::POS_MAX);

    typedef struct packed {
        logic                neg;
        logic                dz;
        logic signed [W-1:0] c;
    } t_side1;

    typedef struct packed {
        logic                 wneg;
        logic                 wz;
        logic [1:0]           base;
        logic [RW-1:0]        region;
        logic signed [OW-1:0] h;
        logic                 fault;
        logic                 dz;
    } t_side2;

    // ---------------------------------------------------------------
    // Calibration registers
    // ---------------------------------------------------------------
    logic signed [plp_pkg::VR_W-1:0] r_vr;
    logic signed [plp_pkg::VC_W-1:0] r_vc;
    logic [plp_pkg::BR_W-1:0]        r_br;
    logic [plp_pkg::BC_W-1:0]        r_bc;
    logic signed [EW-1:0]            r_e [plp_pkg::NUM_EDGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr   <= plp_pkg::VR_RST;
            r_vc   <= plp_pkg::VC_RST;
            r_br   <= plp_pkg::BR_RST;
            r_bc   <= plp_pkg::BC_RST;
            r_e[0] <= plp_pkg::E0_RST;
            r_e[1] <= plp_pkg::E1_RST;
            r_e[2] <= plp_pkg::E2_RST;
            r_e[3] <= plp_pkg::E3_RST;
        end else if (i_cfg_we) begin
            case (plp_pkg::t_reg_idx'(i_cfg_idx))
                plp_pkg::REG_VANISH_ROW:      r_vr   <= i_cfg_data[plp_pkg::VR_W-1:0];
                plp_pkg::REG_VANISH_COL:      r_vc   <= i_cfg_data[plp_pkg::VC_W-1:0];
                plp_pkg::REG_BASE_ROW:        r_br   <= i_cfg_data[plp_pkg::BR_W-1:0];
                plp_pkg::REG_BASE_COL:        r_bc   <= i_cfg_data[plp_pkg::BC_W-1:0];
                plp_pkg::REG_LANE_EDGE_ZERO:  r_e[0] <= i_cfg_data[EW-1:0];
                plp_pkg::REG_LANE_EDGE_ONE:   r_e[1] <= i_cfg_data[EW-1:0];
                plp_pkg::REG_LANE_EDGE_TWO:   r_e[2] <= i_cfg_data[EW-1:0];
                plp_pkg::REG_LANE_EDGE_THREE: r_e[3] <= i_cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global advance: output register empty or being drained
    // ---------------------------------------------------------------
    logic r_o_vld;
    logic adv;

    assign adv         = !r_o_vld || o_lane.ready;
    assign i_pix.ready = adv;

    // ---------------------------------------------------------------
    // Stage A: perspective differences
    // ---------------------------------------------------------------
    logic [PW-1:0]       row_m, col_m;
    logic signed [W-1:0] vr_e, vc_e, row_f, col_f, br_f, bc_f;
    logic signed [W-1:0] n_a_den, n_a_a, n_a_b, n_a_c;

    always_comb begin
        row_m   = i_pix.pixel_row & COORD_MASK;
        col_m   = i_pix.pixel_col & COORD_MASK;
        vr_e    = W'(r_vr);
        vc_e    = W'(r_vc);
        row_f   = W'(row_m) << FRAC_BITS;
        col_f   = W'(col_m) << FRAC_BITS;
        br_f    = W'(r_br) << FRAC_BITS;
        bc_f    = W'(r_bc) << FRAC_BITS;
        n_a_den = vr_e - row_f;    // vanish_row - row
        n_a_a   = br_f - vr_e;     // base_row - vanish_row
        n_a_b   = vc_e - col_f;    // vanish_col - col
        n_a_c   = vc_e - bc_f;     // vanish_col - base_col
    end

    logic                r_a_vld;
    logic signed [W-1:0] r_a_den, r_a_a, r_a_b, r_a_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_den <= n_a_den;
            r_a_a   <= n_a_a;
            r_a_b   <= n_a_b;
            r_a_c   <= n_a_c;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: sign and magnitude
    // ---------------------------------------------------------------
    logic                r_b_vld;
    logic [W-1:0]        r_b_den_mag, r_b_a_mag, r_b_b_mag;
    logic                r_b_neg, r_b_dz;
    logic signed [W-1:0] r_b_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_den_mag <= r_a_den[W-1] ? W'(-r_a_den) : W'(r_a_den);
            r_b_a_mag   <= r_a_a[W-1]   ? W'(-r_a_a)   : W'(r_a_a);
            r_b_b_mag   <= r_a_b[W-1]   ? W'(-r_a_b)   : W'(r_a_b);
            r_b_neg     <= r_a_a[W-1] ^ r_a_b[W-1] ^ r_a_den[W-1];
            r_b_dz      <= (r_a_den == '0);
            r_b_c       <= r_a_c;
        end
    end

    // ---------------------------------------------------------------
    // Stage C: exact product magnitude
    // ---------------------------------------------------------------
    logic [NW1-1:0] prod;
    logic           r_c_vld;
    logic [NW1-1:0] r_c_num;
    logic [W-1:0]   r_c_den;
    t_side1         r_c_side;

    assign prod = r_b_a_mag * r_b_b_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_num  <= prod;
            r_c_den  <= r_b_den_mag;
            r_c_side <= '{neg: r_b_neg, dz: r_b_dz, c: r_b_c};
        end
    end

    // ---------------------------------------------------------------
    // Perspective divider: one cell per quotient bit
    // ---------------------------------------------------------------
    logic           d1_vld;
    logic [NW1-1:0] d1_quo;
    t_side1         d1_side;

    plp_div_chain #(
        .NW (NW1),
        .DW (W),
        .SW ($bits(t_side1))
    ) u_div_ofs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_c_vld),
        .i_num  (r_c_num),
        .i_den  (r_c_den),
        .i_side (r_c_side),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );

    // ---------------------------------------------------------------
    // Stage D1: restore quotient sign (truncation toward zero)
    // ---------------------------------------------------------------
    logic                  r_d_vld;
    logic signed [NW1-1:0] r_d_qs;
    logic signed [W-1:0]   r_d_c;
    logic                  r_d_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_d_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_qs <= d1_side.neg ? -d1_quo : d1_quo;
            r_d_c  <= d1_side.c;
            r_d_dz <= d1_side.dz;
        end
    end

    // ---------------------------------------------------------------
    // Stage D2: add column offset, clamp to offset range
    // ---------------------------------------------------------------
    logic signed [NW1:0]  hw;
    logic signed [OW-1:0] n_h;
    logic                 n_h_sat;

    always_comb begin
        hw      = (NW1+1)'(r_d_qs) + (NW1+1)'(r_d_c);
        n_h_sat = 1'b0;
        n_h     = hw[OW-1:0];
        if (hw > HW_MAX) begin
            n_h     = OW'(plp_pkg::OFS_MAX);
            n_h_sat = 1'b1;
        end else if (hw < HW_MIN) begin
            n_h     = OW'(plp_pkg::OFS_MIN);
            n_h_sat = 1'b1;
        end
    end

    logic                 r_h_vld;
    logic signed [OW-1:0] r_h;
    logic                 r_h_fault, r_h_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (adv) begin
            r_h_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h       <= n_h;
            r_h_fault <= n_h_sat;
            r_h_dz    <= r_d_dz;
        end
    end

    // ---------------------------------------------------------------
    // Stage E1: locate offset against lane edges
    // ---------------------------------------------------------------
    logic [RW-1:0] n_region;

    always_comb begin
        if (r_h < r_e[0]) begin
            n_region = plp_pkg::REGION_LEFT;
        end else if (r_h < r_e[1]) begin
            n_region = plp_pkg::REGION_LANE1;
        end else if (r_h < r_e[2]) begin
            n_region = plp_pkg::REGION_LANE2;
        end else if (r_h < r_e[3]) begin
            n_region = plp_pkg::REGION_LANE3;
        end else begin
            n_region = plp_pkg::REGION_BEYOND;
        end
    end

    logic                 r_r_vld;
    logic [RW-1:0]        r_r_region;
    logic signed [OW-1:0] r_r_h;
    logic                 r_r_fault, r_r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else if (adv) begin
            r_r_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_region <= n_region;
            r_r_h      <= r_h;
            r_r_fault  <= r_h_fault;
            r_r_dz     <= r_h_dz;
        end
    end

    // ---------------------------------------------------------------
    // Stage E2: distance into the lane and lane width
    // ---------------------------------------------------------------
    logic signed [EW:0] he, e0x, e1x, e2x, e3x;
    logic signed [EW:0] n_dist, n_width;
    logic [1:0]         n_base;

    always_comb begin
        he  = (EW+1)'(r_r_h);
        e0x = (EW+1)'(r_e[0]);
        e1x = (EW+1)'(r_e[1]);
        e2x = (EW+1)'(r_e[2]);
        e3x = (EW+1)'(r_e[3]);
        case (r_r_region)
            plp_pkg::REGION_LEFT: begin
                n_dist = e0x - he; n_width = e1x - e0x; n_base = 2'd0;
            end
            plp_pkg::REGION_LANE1: begin
                n_dist = he - e0x; n_width = e1x - e0x; n_base = 2'd0;
            end
            plp_pkg::REGION_LANE2: begin
                n_dist = he - e1x; n_width = e2x - e1x; n_base = 2'd1;
            end
            plp_pkg::REGION_LANE3: begin
                n_dist = he - e2x; n_width = e3x - e2x; n_base = 2'd2;
            end
            default: begin
                // beyond the last edge: third lane's width
                n_dist = he - e3x; n_width = e3x - e2x; n_base = 2'd3;
            end
        endcase
    end

    logic                 r_w_vld;
    logic [DW2-1:0]       r_w_dist;
    logic signed [EW:0]   r_w_width;
    logic [1:0]           r_w_base;
    logic [RW-1:0]        r_w_region;
    logic signed [OW-1:0] r_w_h;
    logic                 r_w_fault, r_w_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if (adv) begin
            r_w_vld <= r_r_vld;
        end
    end

    // distance is never negative and below 2^24
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w_dist   <= n_dist[DW2-1:0];
            r_w_width  <= n_width;
            r_w_base   <= n_base;
            r_w_region <= r_r_region;
            r_w_h      <= r_r_h;
            r_w_fault  <= r_r_fault;
            r_w_dz     <= r_r_dz;
        end
    end

    // ---------------------------------------------------------------
    // Stage E3: width magnitude, divider operands
    // ---------------------------------------------------------------
    logic           r_x_vld;
    logic [NW2-1:0] r_x_num;
    logic [DW2-1:0] r_x_den;
    t_side2         r_x_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (adv) begin
            r_x_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_num  <= {r_w_dist, {FRAC_BITS{1'b0}}};
            r_x_den  <= r_w_width[EW] ? DW2'(-r_w_width) : DW2'(r_w_width);
            r_x_side <= '{wneg:   r_w_width[EW],
                          wz:     (r_w_width == '0),
                          base:   r_w_base,
                          region: r_w_region,
                          h:      r_w_h,
                          fault:  r_w_fault,
                          dz:     r_w_dz};
        end
    end

    // ---------------------------------------------------------------
    // Lane fraction divider
    // ---------------------------------------------------------------
    logic           d2_vld;
    logic [NW2-1:0] d2_quo;
    t_side2         d2_side;

    plp_div_chain #(
        .NW (NW2),
        .DW (DW2),
        .SW ($bits(t_side2))
    ) u_div_pos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_x_vld),
        .i_num  (r_x_num),
        .i_den  (r_x_den),
        .i_side (r_x_side),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_side (d2_side)
    );

    // ---------------------------------------------------------------
    // Stage F1: quotient sign (misordered edges give a negative width)
    // ---------------------------------------------------------------
    logic                r_f_vld;
    logic signed [NW2:0] r_f_qs;
    t_side2              r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_qs   <= d2_side.wneg ? -((NW2+1)'(d2_quo)) : (NW2+1)'(d2_quo);
            r_f_side <= d2_side;
        end
    end

    // ---------------------------------------------------------------
    // Stage F2: add region base, clamp, output register
    // ---------------------------------------------------------------
    logic signed [PSW-1:0] base_f, posw;
    logic [POSW-1:0]       n_pos;
    logic                  n_fault;
    logic signed [OW-1:0]  n_ofs;
    logic [RW-1:0]         n_reg_o;

    always_comb begin
        base_f  = PSW'(r_f_side.base) << FRAC_BITS;
        n_fault = r_f_side.fault;
        if (r_f_side.wz) begin
            // zero lane width: fraction term dropped
            posw    = base_f;
            n_fault = 1'b1;
        end else begin
            posw = PSW'(r_f_qs) + base_f;
        end
        n_pos = posw[POSW-1:0];
        if (posw > PS_MAX) begin
            n_pos   = POSW'(plp_pkg::POS_MAX);
            n_fault = 1'b1;
        end else if (posw < 0) begin
            n_pos   = '0;
            n_fault = 1'b1;
        end
        n_ofs   = r_f_side.h;
        n_reg_o = r_f_side.region;
        if (r_f_side.dz) begin
            // point on the horizon row: no mapping
            n_pos   = '0;
            n_ofs   = '0;
            n_reg_o = plp_pkg::REGION_LEFT;
            n_fault = 1'b1;
        end
    end

    logic [POSW-1:0]      r_o_pos;
    logic signed [OW-1:0] r_o_ofs;
    logic [RW-1:0]        r_o_region;
    logic                 r_o_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_pos    <= n_pos;
            r_o_ofs    <= n_ofs;
            r_o_region <= n_reg_o;
            r_o_fault  <= n_fault;
        end
    end

    assign o_lane.valid         = r_o_vld;
    assign o_lane.lane_position = r_o_pos;
    assign o_lane.cross_offset  = r_o_ofs;
    assign o_lane.region        = r_o_region;
    assign o_lane.fault         = r_o_fault;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic [11:0] stage_vld;

    assign stage_vld = {r_a_vld, r_b_vld, r_c_vld, d1_vld, r_d_vld, r_h_vld,
                        r_r_vld, r_w_vld, r_x_vld, d2_vld, r_f_vld, r_o_vld};

    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_region <= plp_pkg::REGION_BEYOND))
        else $error("region code out of range");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(stage_vld))
        else $error("pipeline moved while stalled");

    a_beyond_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_fault && r_o_region == plp_pkg::REGION_BEYOND)
            |-> (r_o_ofs >= r_e[3]))
        else $error("beyond region below last edge");

    a_left_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_fault && r_o_region == plp_pkg::REGION_LEFT)
            |-> (r_o_ofs < r_e[0]))
        else $error("left region at or past first edge");

endmodule

// ----- hw/rtl/plp_div_cell.sv -----
module plp_div_cell #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_nq,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_nq,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic          r_vld;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_nq;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_side;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_nq;

    // one restoring step: bring down next numerator bit, trial subtract
    always_comb begin
        shifted = {i_rem, i_nq[NW-1]};
        diff    = shifted - {1'b0, i_den};
        ge      = (shifted >= {1'b0, i_den});
        n_rem   = ge ? diff[DW-1:0] : shifted[DW-1:0];
        n_nq    = {i_nq[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

// ----- hw/rtl/plp_div_chain.sv -----
module plp_div_chain #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [NW:0]   vld;
    logic [DW-1:0] rem  [NW+1];
    logic [NW-1:0] nq   [NW+1];
    logic [DW-1:0] den  [NW+1];
    logic [SW-1:0] side [NW+1];

    assign vld[0]  = i_vld;
    assign rem[0]  = '0;
    assign nq[0]   = i_num;
    assign den[0]  = i_den;
    assign side[0] = i_side;

    // one cell per quotient bit, MSB first
    for (genvar g = 0; g < NW; g++) begin : g_cell
        plp_div_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (vld[g]),
            .i_rem  (rem[g]),
            .i_nq   (nq[g]),
            .i_den  (den[g]),
            .i_side (side[g]),
            .o_vld  (vld[g+1]),
            .o_rem  (rem[g+1]),
            .o_nq   (nq[g+1]),
            .o_den  (den[g+1]),
            .o_side (side[g+1])
        );
    end

    assign o_vld  = vld[NW];
    assign o_quo  = nq[NW];
    assign o_side = side[NW];

endmodule

// ----- tb/plp_lane_checker.sv -----
module plp_lane_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [plp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    plp_pix_if         i_pix,
    plp_lane_if        i_lane,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [plp_pkg::POS_W-1:0]           pos;
        logic signed [plp_pkg::OFS_W-1:0]    ofs;
        logic [plp_pkg::REGION_W-1:0]        region;
        logic                                fault;
    } t_lane_result;

    localparam longint ONE = longint'(1) << plp_pkg::FRAC_BITS_DEF;

    // Local calibration copy, signed ones sign-extended
    longint vanish_row, vanish_col, base_row, base_col;
    longint lane_edge [plp_pkg::NUM_EDGES];
    t_lane_result expected_lanes [$];

    function automatic t_lane_result map_pixel(logic [plp_pkg::PIX_W-1:0] row,
                                               logic [plp_pkg::PIX_W-1:0] col);
        t_lane_result r;
        longint den, num, h, lane_dist, width, base, pos;
        logic [plp_pkg::REGION_W-1:0] reg_code;
        logic flt;
        flt = 1'b0;
        den = vanish_row - longint'(row) * ONE;
        if (den == 0) begin
            r = '0;
            r.fault = 1'b1;
            return r;
        end
        num = (base_row * ONE - vanish_row) * (vanish_col - longint'(col) * ONE);
        h = num / den + vanish_col - base_col * ONE;
        if (h > plp_pkg::OFS_MAX) begin h = plp_pkg::OFS_MAX; flt = 1'b1; end
        if (h < plp_pkg::OFS_MIN) begin h = plp_pkg::OFS_MIN; flt = 1'b1; end
        if (h < lane_edge[0]) begin
            reg_code = plp_pkg::REGION_LEFT; lane_dist = lane_edge[0] - h;
            width = lane_edge[1] - lane_edge[0]; base = 0;
        end else if (h < lane_edge[1]) begin
            reg_code = plp_pkg::REGION_LANE1; lane_dist = h - lane_edge[0];
            width = lane_edge[1] - lane_edge[0]; base = 0;
        end else if (h < lane_edge[2]) begin
            reg_code = plp_pkg::REGION_LANE2; lane_dist = h - lane_edge[1];
            width = lane_edge[2] - lane_edge[1]; base = 1;
        end else if (h < lane_edge[3]) begin
            reg_code = plp_pkg::REGION_LANE3; lane_dist = h - lane_edge[2];
            width = lane_edge[3] - lane_edge[2]; base = 2;
        end else begin
            // past the last edge the third lane's width is reused
            reg_code = plp_pkg::REGION_BEYOND; lane_dist = h - lane_edge[3];
            width = lane_edge[3] - lane_edge[2]; base = 3;
        end
        if (width == 0) begin
            flt = 1'b1;
            pos = base * ONE;
        end else begin
            pos = (lane_dist * ONE) / width + base * ONE;
        end
        if (pos > plp_pkg::POS_MAX) begin pos = plp_pkg::POS_MAX; flt = 1'b1; end
        if (pos < 0) begin pos = 0; flt = 1'b1; end
        r.pos = pos[plp_pkg::POS_W-1:0];
        r.ofs = h[plp_pkg::OFS_W-1:0];
        r.region = reg_code;
        r.fault = flt;
        return r;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = expected_lanes.size();

    always @(posedge i_clk) begin
        t_lane_result got, exp_r;
        if (!i_rst_n) begin
            vanish_row <= plp_pkg::VR_RST;
            vanish_col <= plp_pkg::VC_RST;
            base_row   <= plp_pkg::BR_RST;
            base_col   <= plp_pkg::BC_RST;
            lane_edge[0] <= plp_pkg::E0_RST;
            lane_edge[1] <= plp_pkg::E1_RST;
            lane_edge[2] <= plp_pkg::E2_RST;
            lane_edge[3] <= plp_pkg::E3_RST;
        end else begin
            if (i_cfg_we) begin
                case (plp_pkg::t_reg_idx'(i_cfg_idx))
                    plp_pkg::REG_VANISH_ROW:
                        vanish_row <= $signed(i_cfg_data[plp_pkg::VR_W-1:0]);
                    plp_pkg::REG_VANISH_COL:
                        vanish_col <= $signed(i_cfg_data[plp_pkg::VC_W-1:0]);
                    plp_pkg::REG_BASE_ROW:
                        base_row <= i_cfg_data[plp_pkg::BR_W-1:0];
                    plp_pkg::REG_BASE_COL:
                        base_col <= i_cfg_data[plp_pkg::BC_W-1:0];
                    plp_pkg::REG_LANE_EDGE_ZERO:
                        lane_edge[0] <= $signed(i_cfg_data[plp_pkg::EDGE_W-1:0]);
                    plp_pkg::REG_LANE_EDGE_ONE:
                        lane_edge[1] <= $signed(i_cfg_data[plp_pkg::EDGE_W-1:0]);
                    plp_pkg::REG_LANE_EDGE_TWO:
                        lane_edge[2] <= $signed(i_cfg_data[plp_pkg::EDGE_W-1:0]);
                    plp_pkg::REG_LANE_EDGE_THREE:
                        lane_edge[3] <= $signed(i_cfg_data[plp_pkg::EDGE_W-1:0]);
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                expected_lanes.push_back(map_pixel(i_pix.pixel_row, i_pix.pixel_col));
            if (i_lane.valid && i_lane.ready) begin
                got.pos = i_lane.lane_position;
                got.ofs = i_lane.cross_offset;
                got.region = i_lane.region;
                got.fault = i_lane.fault;
                if (expected_lanes.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d ofs=%0d region=%0d fault=%0b",
                             $time, got.pos, got.ofs, got.region, got.fault);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_lanes.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected pos=%0d ofs=%0d region=%0d fault=%0b",
                                 $time, exp_r.pos, exp_r.ofs, exp_r.region, exp_r.fault);
                        $display("%0t:          actual   pos=%0d ofs=%0d region=%0d fault=%0b",
                                 $time, got.pos, got.ofs, got.region, got.fault);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/pixel_to_lane_position_tb.sv -----
module pixel_to_lane_position_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [plp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [plp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;

    plp_pix_if  pix ();
    plp_lane_if lane ();

    pixel_to_lane_position uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pix(pix), .o_lane(lane)
    );

    plp_lane_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pix(pix), .i_lane(lane),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random backpressure at the current stall rate
    always @(posedge i_clk)
        lane.ready <= ($urandom_range(99) >= stall_pct);

    // Hard stop well beyond the slowest legal run
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // One pixel transaction; optional idle cycles before it. Called on a rising edge.
    task automatic send_pixel(input logic [plp_pkg::PIX_W-1:0] row,
                              input logic [plp_pkg::PIX_W-1:0] col);
        while ($urandom_range(99) < idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.pixel_row <= row;
        pix.pixel_col <= col;
        // handshake inputs settle by the falling edge
        do @(negedge i_clk); while (!pix.ready);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input plp_pkg::t_reg_idx idx,
                             input logic [plp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_calibration(input logic [plp_pkg::CFG_DATA_W-1:0] vr, vc, br, bc,
                                    e0, e1, e2, e3);
        write_reg(plp_pkg::REG_VANISH_ROW, vr);
        write_reg(plp_pkg::REG_VANISH_COL, vc);
        write_reg(plp_pkg::REG_BASE_ROW, br);
        write_reg(plp_pkg::REG_BASE_COL, bc);
        write_reg(plp_pkg::REG_LANE_EDGE_ZERO, e0);
        write_reg(plp_pkg::REG_LANE_EDGE_ONE, e1);
        write_reg(plp_pkg::REG_LANE_EDGE_TWO, e2);
        write_reg(plp_pkg::REG_LANE_EDGE_THREE, e3);
        i_cfg_we <= 1'b0;
    endtask

    // Drain everything in flight; the pipeline is ~86 deep
    task automatic drain;
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // Random calibration: mostly plausible geometry, sometimes anything
    task automatic random_calibration;
        logic [plp_pkg::CFG_DATA_W-1:0] vr, vc;
        int e0, w1, w2, w3;
        if ($urandom_range(3) != 0) vr = 24'($urandom_range(1023) << 8);   // hits zero denominators
        else vr = 24'($urandom);
        if ($urandom_range(1) != 0) vc = 24'(($urandom_range(1023) << 8) + $urandom_range(255));
        else vc = 24'($urandom);
        if ($urandom_range(4) == 0) begin
            load_calibration(vr, vc, 24'($urandom), 24'($urandom), 24'($urandom),
                             24'($urandom), 24'($urandom), 24'($urandom));
        end else begin
            e0 = $urandom_range(0, 200000) - 100000;
            w1 = $urandom_range(0, 40000);
            w2 = $urandom_range(0, 40000);
            w3 = $urandom_range(0, 40000);
            load_calibration(vr, vc, 24'($urandom), 24'($urandom), 24'(e0), 24'(e0 + w1),
                             24'(e0 + w1 + w2), 24'(e0 + w1 + w2 + w3));
        end
    endtask

    initial begin
        int phase;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel_row = '0;
        pix.pixel_col = '0;
        lane.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset calibration, field extremes and lane regions
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd180, 10'd27);
        send_pixel(10'd180, 10'd130);
        send_pixel(10'd180, 10'd240);
        send_pixel(10'd180, 10'd330);
        send_pixel(10'd180, 10'd600);
        drain();

        // Vanishing row on a pixel row: zero denominator, neighbors saturate the offset
        load_calibration(24'd100 << 8, 24'd512 << 8, 24'd1023, 24'd0,
                         -24'sd256, 24'sd27648, 24'sd54528, 24'sd80889);
        send_pixel(10'd100, 10'd5);
        send_pixel(10'd99, 10'd0);
        send_pixel(10'd101, 10'd1023);
        send_pixel(10'd101, 10'd0);
        drain();

        // All edges equal: zero lane width on both outer regions
        load_calibration(-24'sd35258, 24'sd20090, 24'd180, 24'd27, 24'd0, 24'd0, 24'd0, 24'd0);
        send_pixel(10'd180, 10'd0);
        send_pixel(10'd180, 10'd1023);
        send_pixel(10'd180, 10'd27);
        drain();

        // Misordered edges and register extremes
        load_calibration(24'h100000, 24'h0FFFFF, 24'd1023, 24'd1023,
                         24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd300);
        drain();
        load_calibration(24'h0FFFFF, 24'h100000, 24'd0, 24'd0,
                         24'sd5000, -24'sd5000, 24'sd20000, 24'sd10000);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd700, 10'd2);
        send_pixel(10'd1000, 10'd900);
        drain();

        // Random phases, cycling through the idle/stall modes
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            if (phase == 0) i_rst_n <= 1'b1;   // keep the last directed setting for phase 0
            else random_calibration();
            repeat (225) begin
                if ($urandom_range(9) == 0 && checker_inst.vanish_row[7:0] == 8'd0)
                    send_pixel(checker_inst.vanish_row[17:8], 10'($urandom));
                else
                    send_pixel(10'($urandom), 10'($urandom));
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/plp_pkg.sv
hw/rtl/plp_pix_if.sv
hw/rtl/plp_lane_if.sv
hw/rtl/plp_div_cell.sv
hw/rtl/plp_div_chain.sv
hw/rtl/pixel_to_lane_position.sv
tb/plp_lane_checker.sv
tb/pixel_to_lane_position_tb.sv
